// ----- sv/sqb_pkg.sv -----
// shared types and constants for the sprite quad batcher
`timescale 1ns / 1ps
package sqb_pkg;
	localparam int MaxTextures  = 16;
	localparam int QuadCapacity = 1024;
	localparam int SlotW  = 4;
	localparam int UsedW  = 5;
	localparam int QcntW  = 11;
	localparam logic [16:0] Q116Max = 17'h1FFFF;

	typedef enum logic [1:0] {
		KIND_BIND = 2'd0,
		KIND_VERTEX = 2'd1,
		KIND_DRAW = 2'd2
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture input item
		logic       div_start; // start division
		logic [1:0] div_sel;   // 0 src_x, 1 src_w, 2 src_y, 3 src_h
		logic       srch_clr;  // restart slot search
		logic       srch_step; // compare one slot
		logic       bind_wr;   // write handle into next slot
		logic       clr_batch;
		logic       quad_inc;
		logic       out_load;
		kind_t      out_kind;
		logic [1:0] out_corner;
		logic       out_last;
	} sqb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_end;
		logic div_busy;
		logic srch_done;
		logic found;
		logic quads_full;
		logic slots_full;
		logic out_busy;
	} sqb_sts_t;
endpackage

// ----- sv/sqb_div.sv -----
// restoring divider for 17-bit saturated texture coordinate ratios
`timescale 1ns / 1ps
module sqb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [14:0] den,
	output logic        busy,
	output logic [16:0] quo
);
	// quotient of (num<<16)/den, one bit per cycle, 32 steps
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [14:0] den_q;
	logic [5:0]  cnt_q;
	logic [31:0] qacc_q;
	logic [16:0] trial;

	assign trial = {rem_q, dvd_q[31]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			cnt_q <= 6'd32;
			busy <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'h0000};
			rem_q <= '0;
			den_q <= den;
			qacc_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				qacc_q <= {qacc_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], dvd_q[31]};
				qacc_q <= {qacc_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (den_q == '0 || qacc_q[31:17] != '0) quo = sqb_pkg::Q116Max;
		else quo = qacc_q[16:0];
	end
endmodule

// ----- sv/sqb_datapath.sv -----
// operand capture, slot table, coordinate math and output register
`timescale 1ns / 1ps
module sqb_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sqb_pkg::sqb_cmd_t     cmd,
	output sqb_pkg::sqb_sts_t     sts,
	input  logic                  opcode,
	input  logic [15:0]           texture_handle,
	input  logic [14:0]           tex_width,
	input  logic [14:0]           tex_height,
	input  logic [15:0]           src_x,
	input  logic [15:0]           src_y,
	input  logic [15:0]           src_w,
	input  logic [15:0]           src_h,
	input  logic signed [23:0]    dest_x,
	input  logic signed [23:0]    dest_y,
	input  logic [22:0]           dest_w,
	input  logic [22:0]           dest_h,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            kind,
	output logic [3:0]            slot,
	output logic [15:0]           bound_handle,
	output logic signed [24:0]    pos_x,
	output logic signed [24:0]    pos_y,
	output logic [16:0]           tex_u,
	output logic [16:0]           tex_v,
	output logic [9:0]            quad_index,
	output logic [1:0]            corner,
	output logic [12:0]           index_total,
	output logic                  last
);
	logic        op_q;
	logic [15:0] hnd_q, sx_q, sy_q, sw_q, sh_q;
	logic [14:0] tw_q, th_q;
	logic signed [24:0] x0_q, y0_q, x1_q, y1_q;
	logic [16:0] u0_q, u1_q, v0_q, v1_q;
	logic [15:0] handles_q [sqb_pkg::MaxTextures];
	logic [sqb_pkg::UsedW-1:0] used_q, idx_q;
	logic [sqb_pkg::SlotW-1:0] slot_q;
	logic        found_q;
	logic [sqb_pkg::QcntW-1:0] qcnt_q;
	logic [15:0] div_num;
	logic [14:0] div_den;
	logic        div_busy, div_busy_d_q;
	logic [16:0] div_quo;
	logic [1:0]  sel_q;
	logic [17:0] sum;
	logic [16:0] sat_sum;

	always_comb begin
		unique case (cmd.div_sel)
			2'd0: begin div_num = sx_q; div_den = tw_q; end
			2'd1: begin div_num = sw_q; div_den = tw_q; end
			2'd2: begin div_num = sy_q; div_den = th_q; end
			default: begin div_num = sh_q; div_den = th_q; end
		endcase
	end

	sqb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign sum = {1'b0, (sel_q[1] ? v0_q : u0_q)} + {1'b0, div_quo};
	assign sat_sum = (sum > {1'b0, sqb_pkg::Q116Max}) ? sqb_pkg::Q116Max : sum[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_d_q <= 1'b0;
		end else begin
			div_busy_d_q <= div_busy;
		end
	end

	// store the quotient or saturated sum when division ends
	always_ff @(posedge clk) begin
		if (cmd.div_start) sel_q <= cmd.div_sel;
		if (div_busy_d_q && !div_busy) begin
			unique case (sel_q)
				2'd0: u0_q <= div_quo;
				2'd1: u1_q <= sat_sum;
				2'd2: v0_q <= div_quo;
				default: v1_q <= sat_sum;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			hnd_q <= texture_handle;
			tw_q <= tex_width;
			th_q <= tex_height;
			sx_q <= src_x;
			sy_q <= src_y;
			sw_q <= src_w;
			sh_q <= src_h;
			x0_q <= {dest_x[23], dest_x};
			y0_q <= {dest_y[23], dest_y};
			x1_q <= {dest_x[23], dest_x} + {2'b00, dest_w};
			y1_q <= {dest_y[23], dest_y} + {2'b00, dest_h};
		end
		if (cmd.bind_wr) handles_q[used_q[sqb_pkg::SlotW-1:0]] <= hnd_q;
	end

	// slot search walks one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			qcnt_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cmd.srch_clr) begin
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.srch_step) begin
				if (handles_q[idx_q[sqb_pkg::SlotW-1:0]] == hnd_q) begin
					found_q <= 1'b1;
					slot_q <= idx_q[sqb_pkg::SlotW-1:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.clr_batch) begin
				used_q <= '0;
				qcnt_q <= '0;
			end else begin
				if (cmd.bind_wr) begin
					used_q <= used_q + 1'b1;
					slot_q <= used_q[sqb_pkg::SlotW-1:0];
				end
				if (cmd.quad_inc) qcnt_q <= qcnt_q + 1'b1;
			end
		end
	end

	assign sts.is_end = op_q;
	assign sts.div_busy = div_busy || cmd.div_start || div_busy_d_q;
	assign sts.srch_done = found_q || (idx_q >= used_q);
	assign sts.found = found_q;
	assign sts.quads_full = qcnt_q >= sqb_pkg::QcntW'(sqb_pkg::QuadCapacity);
	assign sts.slots_full = used_q >= sqb_pkg::UsedW'(sqb_pkg::MaxTextures);
	assign sts.out_busy = out_valid && out_stall;

	logic right, top;
	assign right = (cmd.out_corner == 2'd1) || (cmd.out_corner == 2'd2);
	assign top = cmd.out_corner[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			last <= cmd.out_last;
			slot <= '0;
			bound_handle <= '0;
			pos_x <= '0;
			pos_y <= '0;
			tex_u <= '0;
			tex_v <= '0;
			quad_index <= '0;
			corner <= '0;
			index_total <= '0;
			unique case (cmd.out_kind)
				sqb_pkg::KIND_BIND: begin
					slot <= used_q[sqb_pkg::SlotW-1:0];
					bound_handle <= hnd_q;
				end
				sqb_pkg::KIND_VERTEX: begin
					slot <= slot_q;
					pos_x <= right ? x1_q : x0_q;
					pos_y <= top ? y1_q : y0_q;
					tex_u <= right ? u1_q : u0_q;
					tex_v <= top ? v0_q : v1_q;
					quad_index <= qcnt_q[9:0];
					corner <= cmd.out_corner;
				end
				default: begin
					index_total <= 13'({qcnt_q, 2'b00} + {1'b0, qcnt_q, 1'b0});
				end
			endcase
		end
	end
endmodule

// ----- sv/sqb_ctrl.sv -----
// controller state machine sequencing one item at a time
`timescale 1ns / 1ps
module sqb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sqb_pkg::sqb_sts_t sts,
	output sqb_pkg::sqb_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FULLDRAW, S_SEARCH, S_SLOTCHK, S_BIND,
		S_DIV, S_DIVWAIT, S_VERT, S_END
	} state_t;

	state_t    state_q;
	logic [1:0] dsel_q;
	logic [1:0] corner_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.out_kind = sqb_pkg::KIND_DRAW;
		cmd.out_corner = corner_q;
		cmd.div_sel = dsel_q;
		unique case (state_q)
			S_IDLE: cmd.srch_clr = 1'b1;
			S_DECODE: ;
			S_FULLDRAW, S_END: if (!sts.out_busy) begin
				cmd.out_load = 1'b1;
				cmd.clr_batch = 1'b1;
				cmd.out_last = (state_q == S_END);
			end
			S_SEARCH: if (!sts.srch_done) cmd.srch_step = 1'b1;
			S_SLOTCHK: if (!sts.out_busy && sts.slots_full) begin
				cmd.out_load = 1'b1;
				cmd.clr_batch = 1'b1;
			end
			S_BIND: if (!sts.out_busy) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = sqb_pkg::KIND_BIND;
				cmd.bind_wr = 1'b1;
			end
			S_DIV: cmd.div_start = 1'b1;
			S_DIVWAIT: ;
			S_VERT: if (!sts.out_busy) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = sqb_pkg::KIND_VERTEX;
				cmd.out_last = (corner_q == 2'd3);
				cmd.quad_inc = (corner_q == 2'd3);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dsel_q <= '0;
			corner_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					if (sts.is_end) state_q <= S_END;
					else if (sts.quads_full) state_q <= S_FULLDRAW;
					else state_q <= S_SEARCH;
				end
				S_FULLDRAW: if (!sts.out_busy) state_q <= S_SEARCH;
				S_SEARCH: if (sts.srch_done) begin
					if (sts.found) begin
						dsel_q <= 2'd0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_SLOTCHK;
					end
				end
				S_SLOTCHK: if (!sts.out_busy || !sts.slots_full) state_q <= S_BIND;
				S_BIND: if (!sts.out_busy) begin
					dsel_q <= 2'd0;
					state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DIVWAIT;
				S_DIVWAIT: if (!sts.div_busy) begin
					if (dsel_q == 2'd3) begin
						corner_q <= '0;
						state_q <= S_VERT;
					end else begin
						dsel_q <= dsel_q + 2'd1;
						state_q <= S_DIV;
					end
				end
				S_VERT: if (!sts.out_busy) begin
					corner_q <= corner_q + 2'd1;
					if (corner_q == 2'd3) state_q <= S_IDLE;
				end
				S_END: if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/sprite_quad_batcher.sv -----
// top level of the sprite quad batcher
// one item at a time: a draw item runs four divisions on one shared divider, a slot search
// of one entry per cycle and up to six results
// a new item is taken once the last result is loaded
// the output register lets the next item start while the final result waits
// asynchronous reset clears the batch counts and the controller; slot table is not cleared
`timescale 1ns / 1ps
module sprite_quad_batcher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [15:0]        texture_handle,
	input  logic [14:0]        tex_width,
	input  logic [14:0]        tex_height,
	input  logic [15:0]        src_x,
	input  logic [15:0]        src_y,
	input  logic [15:0]        src_w,
	input  logic [15:0]        src_h,
	input  logic signed [23:0] dest_x,
	input  logic signed [23:0] dest_y,
	input  logic [22:0]        dest_w,
	input  logic [22:0]        dest_h,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [3:0]         slot,
	output logic [15:0]        bound_handle,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [9:0]         quad_index,
	output logic [1:0]         corner,
	output logic [12:0]        index_total,
	output logic               last
);
	sqb_pkg::sqb_cmd_t cmd;
	sqb_pkg::sqb_sts_t sts;

	sqb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	sqb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(opcode), .texture_handle(texture_handle),
		.tex_width(tex_width), .tex_height(tex_height),
		.src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
		.dest_x(dest_x), .dest_y(dest_y), .dest_w(dest_w), .dest_h(dest_h),
		.out_stall(out_stall), .out_valid(out_valid), .kind(kind), .slot(slot),
		.bound_handle(bound_handle), .pos_x(pos_x), .pos_y(pos_y),
		.tex_u(tex_u), .tex_v(tex_v), .quad_index(quad_index), .corner(corner),
		.index_total(index_total), .last(last)
	);
endmodule

// ----- test/tb.sv -----
// testbench for the sprite quad batcher: table-driven and random sprite items against a predictor
`timescale 1ns / 1ps
module tb;
	typedef struct {
		bit        op;
		bit [15:0] handle;
		bit [14:0] tw;
		bit [14:0] th;
		bit [15:0] sx;
		bit [15:0] sy;
		bit [15:0] sw;
		bit [15:0] sh;
		bit [23:0] dx;
		bit [23:0] dy;
		bit [22:0] dw;
		bit [22:0] dh;
	} sprite_t;

	typedef struct {
		bit [1:0]  kind;
		bit [3:0]  slot;
		bit [15:0] handle;
		bit [24:0] px;
		bit [24:0] py;
		bit [16:0] u;
		bit [16:0] v;
		bit [9:0]  qi;
		bit [1:0]  corner;
		bit [12:0] itot;
		bit        last;
	} quad_out_t;

	typedef struct {
		sprite_t   it;
		bit        typed;
		bit [12:0] itot;
	} row_t;

	localparam bit OP_DRAW = 1'b0;
	localparam bit OP_END  = 1'b1;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic opcode;
	logic [15:0] texture_handle, src_x, src_y, src_w, src_h, bound_handle;
	logic [14:0] tex_width, tex_height;
	logic signed [23:0] dest_x, dest_y;
	logic [22:0] dest_w, dest_h;
	logic [1:0] kind, corner;
	logic [3:0] slot;
	logic signed [24:0] pos_x, pos_y;
	logic [16:0] tex_u, tex_v;
	logic [9:0] quad_index;
	logic [12:0] index_total;
	logic last;

	sprite_quad_batcher u_top (.*);

	quad_out_t quad_q[$];
	bit [15:0] bound_slots[sqb_pkg::MaxTextures];
	int        slots_used, quad_count;
	int        fails;
	bit        quiet, hold_req;
	bit [15:0] handle_pool[20];
	row_t      rows[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic bit [16:0] norm_q116(bit [15:0] val, bit [14:0] size);
		bit [31:0] q;
		if (size == 0) return sqb_pkg::Q116Max;
		q = {val, 16'h0} / size;
		return (q > sqb_pkg::Q116Max) ? sqb_pkg::Q116Max : q[16:0];
	endfunction

	function automatic bit [16:0] sat_sum(bit [16:0] a, bit [16:0] b);
		bit [17:0] s;
		s = a + b;
		return (s > sqb_pkg::Q116Max) ? sqb_pkg::Q116Max : s[16:0];
	endfunction

	function automatic void push_draw();
		quad_out_t r;
		r = '{default: 0};
		r.kind = sqb_pkg::KIND_DRAW;
		r.itot = 13'(quad_count * 6);
		quad_q.push_back(r);
		quad_count = 0;
		slots_used = 0;
	endfunction

	function automatic void predict_quads(sprite_t it);
		quad_out_t r;
		int s;
		bit hit;
		bit [16:0] u0, u1, v0, v1;
		bit [24:0] x0, y0, x1, y1;
		s = 0;
		hit = 0;
		if (it.op == OP_END) begin
			push_draw();
		end else begin
			if (quad_count >= sqb_pkg::QuadCapacity) push_draw();
			for (int i = 0; i < slots_used; i++)
				if (!hit && bound_slots[i] == it.handle) begin
					hit = 1;
					s = i;
				end
			if (!hit) begin
				if (slots_used >= sqb_pkg::MaxTextures) push_draw();
				s = slots_used;
				bound_slots[s] = it.handle;
				slots_used++;
				r = '{default: 0};
				r.kind = sqb_pkg::KIND_BIND;
				r.slot = s[3:0];
				r.handle = it.handle;
				quad_q.push_back(r);
			end
			u0 = norm_q116(it.sx, it.tw);
			u1 = sat_sum(u0, norm_q116(it.sw, it.tw));
			v0 = norm_q116(it.sy, it.th);
			v1 = sat_sum(v0, norm_q116(it.sh, it.th));
			x0 = {it.dx[23], it.dx};
			y0 = {it.dy[23], it.dy};
			x1 = x0 + {2'b0, it.dw};
			y1 = y0 + {2'b0, it.dh};
			for (int k = 0; k < 4; k++) begin
				r = '{default: 0};
				r.kind = sqb_pkg::KIND_VERTEX;
				r.slot = s[3:0];
				r.px = (k == 1 || k == 2) ? x1 : x0;
				r.py = (k >= 2) ? y1 : y0;
				r.u = (k == 1 || k == 2) ? u1 : u0;
				r.v = (k >= 2) ? v0 : v1;
				r.qi = quad_count[9:0];
				r.corner = k[1:0];
				quad_q.push_back(r);
			end
			quad_count++;
		end
		quad_q[$].last = 1'b1;
	endfunction

	task automatic send_sprite(sprite_t it);
		@(negedge clk);
		opcode = it.op;
		texture_handle = it.handle;
		tex_width = it.tw;
		tex_height = it.th;
		src_x = it.sx;
		src_y = it.sy;
		src_w = it.sw;
		src_h = it.sh;
		dest_x = it.dx;
		dest_y = it.dy;
		dest_w = it.dw;
		dest_h = it.dh;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_quads(it);
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18) - 1) @(negedge clk);
		end
	endtask

	function automatic sprite_t rand_sprite(bit force_draw);
		sprite_t it;
		it.op = (!force_draw && $urandom_range(0, 15) == 0) ? OP_END : OP_DRAW;
		it.handle = ($urandom_range(0, 4) == 0) ? 16'($urandom)
			: handle_pool[$urandom_range(0, 19)];
		case ($urandom_range(0, 9))
			0: it.tw = 0;
			1, 2, 3, 4: it.tw = 15'($urandom_range(1, 64));
			default: it.tw = 15'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: it.th = 0;
			1, 2, 3, 4: it.th = 15'($urandom_range(1, 64));
			default: it.th = 15'($urandom);
		endcase
		it.sx = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 64));
		it.sy = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 64));
		it.sw = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 64));
		it.sh = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 64));
		it.dx = 24'($urandom);
		it.dy = 24'($urandom);
		it.dw = 23'($urandom);
		it.dh = 23'($urandom);
		return it;
	endfunction

	function automatic void add_row(bit op, bit [15:0] h, bit [14:0] tw, bit [14:0] th,
			bit [15:0] sx, bit [15:0] sy, bit [15:0] sw, bit [15:0] sh,
			bit [23:0] dx, bit [23:0] dy, bit [22:0] dw, bit [22:0] dh,
			bit typed, bit [12:0] itot);
		row_t r;
		r.it = '{op, h, tw, th, sx, sy, sw, sh, dx, dy, dw, dh};
		r.typed = typed;
		r.itot = itot;
		rows.push_back(r);
	endfunction

	// receiver: random stall bursts, one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		quad_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (quad_q.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
			end else begin
				e = quad_q.pop_front();
				check_field("kind", e.kind, kind);
				check_field("slot", e.slot, slot);
				check_field("bound_handle", e.handle, bound_handle);
				check_field("pos_x", e.px, $unsigned(pos_x));
				check_field("pos_y", e.py, $unsigned(pos_y));
				check_field("tex_u", e.u, tex_u);
				check_field("tex_v", e.v, tex_v);
				check_field("quad_index", e.qi, quad_index);
				check_field("corner", e.corner, corner);
				check_field("index_total", e.itot, index_total);
				check_field("last", e.last, last);
			end
		end
	end

	initial begin
		sprite_t it;
		fails = 0;
		quiet = 0;
		hold_req = 0;
		slots_used = 0;
		quad_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 0;
		texture_handle = 0;
		tex_width = 0;
		tex_height = 0;
		src_x = 0;
		src_y = 0;
		src_w = 0;
		src_h = 0;
		dest_x = 0;
		dest_y = 0;
		dest_w = 0;
		dest_h = 0;
		foreach (handle_pool[i]) handle_pool[i] = 16'($urandom);
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty end right after reset
		add_row(OP_END, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 13'd0);
		add_row(OP_DRAW, 16'h0000, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_DRAW, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 0, 0);
		add_row(OP_DRAW, 16'h1234, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 0, 0);
		// zero divisors
		add_row(OP_DRAW, 16'h1234, 0, 0, 16'd5, 16'd7, 16'd3, 16'd9,
			24'hFFFF00, 24'h000100, 23'h000200, 23'h000300, 0, 0);
		// same handle, other size
		add_row(OP_DRAW, 16'h1234, 15'd256, 15'h4000, 16'd64, 16'd128, 16'd32, 16'd16,
			24'h001000, 24'hFF0000, 23'h001000, 23'h000800, 0, 0);
		add_row(OP_DRAW, 16'h0000, 15'd3, 15'd7, 16'd1, 16'd2, 16'd1, 16'd5,
			24'h123456, 24'hABCDEF, 23'h2AAAAA, 23'h555555, 0, 0);
		add_row(OP_END, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 13'd36);
		// seventeen new handles overflow the slot table
		for (int i = 0; i < 17; i++)
			add_row(OP_DRAW, 16'(16'h0A00 + i), 15'd100, 15'd50, 16'(i * 10), 16'(i * 3),
				16'd20, 16'd30, 24'(i << 10), 24'(-(i << 9)), 23'h400, 23'h800, 0, 0);
		add_row(OP_END, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 13'd6);
		foreach (rows[i]) begin
			send_sprite(rows[i].it);
			if (rows[i].typed) begin
				quad_q[$].kind = sqb_pkg::KIND_DRAW;
				quad_q[$].itot = rows[i].itot;
			end
			sender_gap();
		end

		for (int n = 0; n < 330; n++) begin
			if (n == 100) hold_req = 1'b1;
			if (n == 200) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait (quad_q.size() == 0);
			end
			send_sprite(rand_sprite(0));
			sender_gap();
		end

		// no idling in the last stretch, few textures
		quiet = 1'b1;
		send_sprite('{OP_END, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0});
		for (int n = 0; n < 20; n++) begin
			it = rand_sprite(1);
			it.handle = handle_pool[$urandom_range(0, 2)];
			send_sprite(it);
		end
		send_sprite('{OP_END, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0});
		@(negedge clk);
		in_valid = 1'b0;

		wait (quad_q.size() == 0);
		repeat (300) @(posedge clk);
		if (fails == 0 && quad_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
sv/sqb_pkg.sv
sv/sqb_div.sv
sv/sqb_datapath.sv
sv/sqb_ctrl.sv
sv/sprite_quad_batcher.sv
test/tb.sv
